// ===== rtl/core/sequenced_command_frame_receiver_top_defines.svh =====
// Assertion macros shared by the receiver RTL.
`ifndef SEQUENCED_COMMAND_FRAME_RECEIVER_TOP_DEFINES_SVH
`define SEQUENCED_COMMAND_FRAME_RECEIVER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SCFR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scfr assertion failed");

// Next-cycle implication, checked outside reset.
`define SCFR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scfr assertion failed");

`endif

// ===== rtl/core/scfr_pkg.sv =====
`timescale 1ns / 1ps

package scfr_pkg;

  localparam logic [7:0] START_BAR    = 8'h7C;
  localparam logic [7:0] NEWLINE      = 8'h0A;
  localparam int         BACKWARD_BIT = 7;

  // Item modes.
  localparam logic [1:0] MODE_BYTE    = 2'd0;
  localparam logic [1:0] MODE_ADVANCE = 2'd1;
  localparam logic [1:0] MODE_STATUS  = 2'd2;

  // Result kinds.
  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_TX     = 1'b1;

  // Positions within a frame.
  localparam logic [2:0] POS_BAR    = 3'd0;
  localparam logic [2:0] POS_NUM0   = 3'd1;
  localparam logic [2:0] POS_NUM3   = 3'd4;
  localparam logic [2:0] POS_STATE  = 3'd5;
  localparam logic [2:0] POS_ACTION = 3'd6;
  localparam logic [2:0] POS_END    = 3'd7;

  // Beats of the outgoing status frame.
  localparam logic [2:0] BEAT_BAR  = 3'd0;
  localparam logic [2:0] BEAT_N3   = 3'd1;
  localparam logic [2:0] BEAT_N2   = 3'd2;
  localparam logic [2:0] BEAT_N1   = 3'd3;
  localparam logic [2:0] BEAT_N0   = 3'd4;
  localparam logic [2:0] BEAT_PAD  = 3'd5;
  localparam logic [2:0] BEAT_LAST = 3'd6;

  // Configuration registers.
  localparam logic       REG_OFF_STATE   = 1'b0;
  localparam logic       REG_START_STATE = 1'b1;
  localparam logic [7:0] OFF_STATE_RST   = 8'h00;
  localparam logic [7:0] START_STATE_RST = 8'h01;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  tx_byte;
    logic        tx_last;
    logic        frame_error;
    logic        frame_accepted;
    logic        game_off_event;
    logic        cmd_ready;
    logic        cmd_backward;
    logic [7:0]  cmd_data;
    logic [31:0] cmd_number;
    logic [7:0]  game_state;
  } out_item_t;

  typedef struct packed {
    logic frame_error;
    logic frame_accepted;
    logic game_off_event;
  } scfr_flags_t;

  typedef struct packed {
    logic [31:0] cmd_number;
    logic        cmd_backward;
    logic [7:0]  cmd_data;
    logic [7:0]  game_state;
    logic [31:0] ack_number;
  } scfr_view_t;

endpackage

// ===== rtl/core/scfr_frame.sv =====
`timescale 1ns / 1ps

module scfr_frame (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  scfr_pkg::in_item_t   item,
  input  logic [7:0]           off_state_code,
  output scfr_pkg::scfr_flags_t flags,
  output scfr_pkg::scfr_view_t  view
);
  import scfr_pkg::*;

  logic [2:0]  pos_r,        pos_nxt;
  logic [31:0] num_acc_r,    num_acc_nxt;
  logic [7:0]  pend_state_r, pend_state_nxt;
  logic [7:0]  pend_act_r,   pend_act_nxt;
  logic [31:0] cur_num_r,    cur_num_nxt;
  logic        cur_bw_r,     cur_bw_nxt;
  logic [7:0]  cur_data_r,   cur_data_nxt;
  logic [31:0] nx_num_r,     nx_num_nxt;
  logic        nx_bw_r,      nx_bw_nxt;
  logic [7:0]  nx_data_r,    nx_data_nxt;
  logic [31:0] ack_r,        ack_nxt;
  logic [7:0]  game_r,       game_nxt;
  logic        fresh;
  logic [7:0]  b;

  assign b = item.rx_byte;
  // A frame must carry a number above the acknowledged number and both buffered ones.
  assign fresh = (num_acc_r > ack_r) && (num_acc_r > nx_num_r) && (num_acc_r > cur_num_r);

  always_comb begin
    pos_nxt        = pos_r;
    num_acc_nxt    = num_acc_r;
    pend_state_nxt = pend_state_r;
    pend_act_nxt   = pend_act_r;
    cur_num_nxt    = cur_num_r;
    cur_bw_nxt     = cur_bw_r;
    cur_data_nxt   = cur_data_r;
    nx_num_nxt     = nx_num_r;
    nx_bw_nxt      = nx_bw_r;
    nx_data_nxt    = nx_data_r;
    ack_nxt        = ack_r;
    game_nxt       = game_r;
    flags          = '0;
    if (step && item.mode == MODE_BYTE) begin
      if (pos_r == POS_BAR) begin
        if (b == START_BAR) begin
          num_acc_nxt = '0;
          pos_nxt     = POS_NUM0;
        end
      end else if (pos_r <= POS_ACTION && b == NEWLINE) begin
        flags.frame_error = 1'b1;
        pos_nxt           = POS_BAR;
      end else if (pos_r <= POS_NUM3) begin
        num_acc_nxt = {num_acc_r[23:0], b};
        pos_nxt     = pos_r + 3'd1;
      end else if (pos_r == POS_STATE) begin
        pend_state_nxt = b;
        pos_nxt        = POS_ACTION;
      end else if (pos_r == POS_ACTION) begin
        pend_act_nxt = b;
        pos_nxt      = POS_END;
      end else begin
        pos_nxt = POS_BAR;
        if (b != NEWLINE) begin
          flags.frame_error = 1'b1;
        end else if (fresh) begin
          flags.frame_accepted = 1'b1;
          game_nxt             = pend_state_r;
          if (pend_state_r == off_state_code) begin
            flags.game_off_event = 1'b1;
            cur_num_nxt  = '0;
            cur_bw_nxt   = 1'b0;
            cur_data_nxt = '0;
            nx_num_nxt   = '0;
            nx_bw_nxt    = 1'b0;
            nx_data_nxt  = '0;
          end else if (cur_num_r == '0) begin
            cur_num_nxt  = num_acc_r;
            cur_bw_nxt   = pend_act_r[BACKWARD_BIT];
            cur_data_nxt = pend_act_r;
          end else begin
            nx_num_nxt  = num_acc_r;
            nx_bw_nxt   = pend_act_r[BACKWARD_BIT];
            nx_data_nxt = pend_act_r;
          end
        end
      end
    end else if (step && item.mode == MODE_ADVANCE) begin
      if (cur_num_r > ack_r) begin
        ack_nxt = cur_num_r;
      end
      cur_num_nxt  = nx_num_r;
      cur_bw_nxt   = nx_bw_r;
      cur_data_nxt = nx_data_r;
      nx_num_nxt   = '0;
    end
  end

  // The result shows the state as it stands after this item.
  assign view.cmd_number   = cur_num_nxt;
  assign view.cmd_backward = cur_bw_nxt;
  assign view.cmd_data     = cur_data_nxt;
  assign view.game_state   = game_nxt;
  assign view.ack_number   = ack_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= POS_BAR;
      num_acc_r    <= '0;
      pend_state_r <= '0;
      pend_act_r   <= '0;
      cur_num_r    <= '0;
      cur_bw_r     <= 1'b0;
      cur_data_r   <= '0;
      nx_num_r     <= '0;
      nx_bw_r      <= 1'b0;
      nx_data_r    <= '0;
      ack_r        <= '0;
      game_r       <= START_STATE_RST;
    end else begin
      pos_r        <= pos_nxt;
      num_acc_r    <= num_acc_nxt;
      pend_state_r <= pend_state_nxt;
      pend_act_r   <= pend_act_nxt;
      cur_num_r    <= cur_num_nxt;
      cur_bw_r     <= cur_bw_nxt;
      cur_data_r   <= cur_data_nxt;
      nx_num_r     <= nx_num_nxt;
      nx_bw_r      <= nx_bw_nxt;
      nx_data_r    <= nx_data_nxt;
      ack_r        <= ack_nxt;
      game_r       <= game_nxt;
    end
  end

endmodule

// ===== rtl/core/sequenced_command_frame_receiver_top.sv =====
`timescale 1ns / 1ps

// Command frame receiver. Each request carries a link byte, an advance or a
// status request; byte and advance requests produce one status result each and
// can be taken every cycle while the output is not stalled; each passes through
// an input register and then a result register on its way to the result. A
// status request produces seven transmit results ('|', the acknowledged number
// big-endian, a zero byte and a newline) and holds the input register until its
// last result is taken into the output register, since every result passes
// through the single output register. The start state code register has no
// effect on the game state; reset restores it to one, and the game state after
// reset is one. No clearing pass follows reset.
module sequenced_command_frame_receiver_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  scfr_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output scfr_pkg::out_item_t out_item,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [2:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);
  import scfr_pkg::*;

`include "sequenced_command_frame_receiver_top_defines.svh"

  logic        item_valid_r;
  in_item_t    item_r;
  logic [2:0]  beat_r, beat_nxt;
  logic        out_valid_r;
  out_item_t   out_r, result;
  logic [7:0]  off_state_r;
  logic [7:0]  start_state_r;
  logic        out_free, is_status, emit, item_done, step, cfg_wr;
  logic [7:0]  status_byte;
  scfr_flags_t flags;
  scfr_view_t  view;

  assign out_free  = !out_valid_r || out_ready;
  assign is_status = (item_r.mode == MODE_STATUS);
  assign emit      = item_valid_r && out_free;
  assign item_done = emit && (!is_status || beat_r == BEAT_LAST);
  assign step      = emit && !is_status;
  assign in_ready  = !item_valid_r || item_done;
  assign beat_nxt  = (beat_r == BEAT_LAST) ? BEAT_BAR : beat_r + 3'd1;

  scfr_frame u_frame (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (step),
    .item           (item_r),
    .off_state_code (off_state_r),
    .flags          (flags),
    .view           (view)
  );

  always_comb begin
    case (beat_r)
      BEAT_BAR:  status_byte = START_BAR;
      BEAT_N3:   status_byte = view.ack_number[31:24];
      BEAT_N2:   status_byte = view.ack_number[23:16];
      BEAT_N1:   status_byte = view.ack_number[15:8];
      BEAT_N0:   status_byte = view.ack_number[7:0];
      BEAT_PAD:  status_byte = 8'h00;
      BEAT_LAST: status_byte = NEWLINE;
      default:   status_byte = 8'h00;
    endcase
  end

  always_comb begin
    result.cmd_ready    = (view.cmd_number != '0);
    result.cmd_backward = view.cmd_backward;
    result.cmd_data     = view.cmd_data;
    result.cmd_number   = view.cmd_number;
    result.game_state   = view.game_state;
    if (is_status) begin
      result.result_kind    = KIND_TX;
      result.tx_byte        = status_byte;
      result.tx_last        = (beat_r == BEAT_LAST);
      result.frame_error    = 1'b0;
      result.frame_accepted = 1'b0;
      result.game_off_event = 1'b0;
    end else begin
      result.result_kind    = KIND_STATUS;
      result.tx_byte        = 8'h00;
      result.tx_last        = 1'b1;
      result.frame_error    = flags.frame_error;
      result.frame_accepted = flags.frame_accepted;
      result.game_off_event = flags.game_off_event;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      beat_r       <= BEAT_BAR;
      out_valid_r  <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        item_valid_r <= 1'b1;
      end else if (item_done) begin
        item_valid_r <= 1'b0;
      end
      if (emit && is_status) begin
        beat_r <= beat_nxt;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
    if (emit) begin
      out_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // Configuration port: one byte register per word address.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_state_r   <= OFF_STATE_RST;
      start_state_r <= START_STATE_RST;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        REG_OFF_STATE:   off_state_r   <= cfg_pwdata[7:0];
        REG_START_STATE: start_state_r <= cfg_pwdata[7:0];
        default:         off_state_r   <= off_state_r;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      REG_OFF_STATE:   cfg_prdata = {24'h000000, off_state_r};
      REG_START_STATE: cfg_prdata = {24'h000000, start_state_r};
      default:         cfg_prdata = 32'h00000000;
    endcase
  end

  `SCFR_ASSERT_IMP(a_beat_owner, clk, rst_n, beat_r != BEAT_BAR, item_valid_r && is_status)
  `SCFR_ASSERT_NXT(a_status_end, clk, rst_n, emit && is_status && beat_r == BEAT_LAST, out_valid_r && out_r.tx_last && out_r.tx_byte == NEWLINE && beat_r == BEAT_BAR)
  `SCFR_ASSERT_IMP(a_accept_clean, clk, rst_n, out_valid_r && out_r.frame_accepted, !out_r.frame_error && out_r.result_kind == KIND_STATUS)

endmodule
